// File: src/bpfm_pkg.sv
// Shared types and constants of the buffer pool frame manager.
// Used by bpfm_ctrl, bpfm_datapath and buffer_pool_frame_manager_top.
package bpfm_pkg;

   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int FIDX_OUT_W  = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = 5;

   localparam logic [CMD_W-1:0] CMD_PIN   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UNPIN = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DIRTY = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FORCE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NOT_RES  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NO_FRAME = 2'd2;

   localparam logic [1:0] POL_FIFO  = 2'd0;
   localparam logic [1:0] POL_LRU   = 2'd1;
   localparam logic [1:0] POL_CLOCK = 2'd2;
   localparam logic [1:0] POL_LFU   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAMES = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLK_RD,
      ST_CLK_EV,
      ST_FINISH,
      ST_FL_RD,
      ST_FL_EV,
      ST_FL_END
   } bpfm_state_type;

   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic clk_read;
      logic clk_eval;
      logic finish;
      logic fl_read;
      logic fl_eval;
      logic fl_end;
   } bpfm_cmd_type;

   typedef struct packed {
      logic is_flush;
      logic scan_done;
      logic need_clock;
      logic clk_exhausted;
      logic clk_hit;
      logic fl_done;
      logic out_free;
   } bpfm_stat_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

endpackage

// File: src/bpfm_ctrl.sv
// Command sequencer of the buffer pool frame manager.
// Depends on bpfm_pkg; drives the datapath through bpfm_cmd_type.
module bpfm_ctrl import bpfm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  bpfm_stat_type stat,
   output bpfm_cmd_type  ctl
);

   bpfm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.is_flush) state_in = ST_FL_RD;
            else if (stat.scan_done) state_in = stat.need_clock ? ST_CLK_RD : ST_FINISH;
         end
         ST_CLK_RD: begin
            state_in = stat.clk_exhausted ? ST_FINISH : ST_CLK_EV;
         end
         ST_CLK_EV: begin
            state_in = stat.clk_hit ? ST_FINISH : ST_CLK_RD;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_FL_RD: begin
            state_in = stat.fl_done ? ST_FL_END : ST_FL_EV;
         end
         ST_FL_EV: begin
            if (stat.out_free) state_in = ST_FL_RD;
         end
         ST_FL_END: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      ctl           = '0;
      ctl.load_req  = (state_ff == ST_IDLE) && req_valid;
      ctl.scan_step = (state_ff == ST_SCAN) && !stat.is_flush;
      ctl.clk_read  = (state_ff == ST_CLK_RD) && !stat.clk_exhausted;
      ctl.clk_eval  = (state_ff == ST_CLK_EV);
      ctl.finish    = (state_ff == ST_FINISH) && stat.out_free;
      ctl.fl_read   = (state_ff == ST_FL_RD) && !stat.fl_done;
      ctl.fl_eval   = (state_ff == ST_FL_EV) && stat.out_free;
      ctl.fl_end    = (state_ff == ST_FL_END) && stat.out_free;
   end

endmodule

// File: src/bpfm_datapath.sv
// Frame table memory, scan logic, counters and result register.
// Depends on bpfm_pkg; sequenced by bpfm_ctrl.
module bpfm_datapath import bpfm_pkg::*; #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpfm_cmd_type           ctl,
   output bpfm_stat_type          stat,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [PAGE_BITS-1:0]   req_page_number,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [FIDX_OUT_W-1:0]  rsp_frame_index,
   output logic                   rsp_hit,
   output logic                   rsp_load_needed,
   output logic                   rsp_writeback_valid,
   output logic [PAGE_BITS-1:0]   rsp_writeback_page,
   output logic [31:0]            rsp_read_io_total,
   output logic [31:0]            rsp_write_io_total,
   output logic                   rsp_last
);

   localparam int IDX_W  = $clog2(FRAMES);
   localparam int CNT_W  = $clog2(FRAMES + 1);
   localparam int STEP_W = $clog2(2 * FRAMES + 2);

   typedef struct packed {
      logic [PAGE_BITS-1:0] page;
      logic [7:0]           pins;
      logic                 dirty;
      logic [15:0]          hits;
      logic [31:0]          use_stamp;
      logic [31:0]          load_stamp;
      logic                 ref_bit;
   } entry_type;

   // configuration
   logic [1:0]  policy_ff, policy_in;
   logic [4:0]  frames_ff, frames_in;
   logic [CNT_W-1:0] n_cfg;

   // command
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [CNT_W-1:0]     n_ff, n_in;

   // frame table
   entry_type mem [FRAMES];
   logic [FRAMES-1:0] valid_ff, valid_in;
   entry_type         rd_raw_ff;
   entry_type         rd_entry;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   // lookup scan
   logic             rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic             scan_issue;
   logic             match_found_ff, match_found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   entry_type        match_entry_ff, match_entry_in;
   logic             inval_found_ff, inval_found_in;
   logic [IDX_W-1:0] inval_idx_ff, inval_idx_in;
   logic             best_found_ff, best_found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      best_key_ff, best_key_in;
   logic             best_dirty_ff, best_dirty_in;
   logic [PAGE_BITS-1:0] best_page_ff, best_page_in;
   logic [31:0]      key;

   // clock scan
   logic [IDX_W-1:0]  hand_ff, hand_in;
   logic [IDX_W-1:0]  clk_h_ff, clk_h_in;
   logic [IDX_W-1:0]  clk_h_nx;
   logic [STEP_W-1:0] clk_step_ff, clk_step_in;
   logic              vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]  vic_idx_ff, vic_idx_in;
   logic              vic_dirty_ff, vic_dirty_in;
   logic [PAGE_BITS-1:0] vic_page_ff, vic_page_in;

   // flush
   logic [CNT_W-1:0]     fl_idx_ff, fl_idx_in;
   logic [RES_CNT_W-1:0] fl_cnt_ff, fl_cnt_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [PAGE_BITS-1:0] pend_page_ff, pend_page_in;
   logic [31:0]          pend_wtot_ff, pend_wtot_in;

   // totals
   logic [31:0] tick_ff, tick_in;
   logic [31:0] loads_ff, loads_in;
   logic [31:0] writes_ff, writes_in;

   // result register
   logic                  out_push;
   logic                  out_free;
   logic [STATUS_W-1:0]   o_status;
   logic [IDX_W-1:0]      o_idx;
   logic                  o_hit, o_ld, o_wv, o_last;
   logic [PAGE_BITS-1:0]  o_page;
   logic [31:0]           o_rtot, o_wtot;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [FIDX_OUT_W-1:0] rsp_fi_ff;
   logic                  rsp_hit_ff, rsp_ld_ff, rsp_wv_ff, rsp_last_ff;
   logic [PAGE_BITS-1:0]  rsp_page_ff;
   logic [31:0]           rsp_rtot_ff, rsp_wtot_ff;

   // finish decision
   logic             vic_ok;
   logic [IDX_W-1:0] vic_sel;
   logic             vic_sel_dirty;
   logic [PAGE_BITS-1:0] vic_sel_page;
   logic             fl_qual;

   always_comb begin
      if (frames_ff == 5'd0) n_cfg = CNT_W'(1);
      else if (int'(frames_ff) > FRAMES) n_cfg = CNT_W'(FRAMES);
      else n_cfg = CNT_W'(frames_ff);
   end

   assign rd_entry = valid_ff[rd_idx_ff] ? rd_raw_ff : '0;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign scan_issue = ctl.scan_step && (scan_addr_ff < n_ff);
   assign fl_qual = valid_ff[rd_idx_ff] && rd_entry.dirty && (rd_entry.pins == 8'd0);
   assign clk_h_nx = ((CNT_W'(clk_h_ff) + CNT_W'(1)) == n_ff) ? '0 : clk_h_ff + IDX_W'(1);

   always_comb begin
      case (policy_ff)
         POL_FIFO: key = rd_entry.load_stamp;
         POL_LRU:  key = rd_entry.use_stamp;
         default:  key = {16'd0, rd_entry.hits};
      endcase
   end

   always_comb begin
      if (policy_ff == POL_CLOCK) begin
         vic_ok        = inval_found_ff || vic_found_ff;
         vic_sel       = inval_found_ff ? inval_idx_ff : vic_idx_ff;
         vic_sel_dirty = !inval_found_ff && vic_dirty_ff;
         vic_sel_page  = vic_page_ff;
      end else begin
         vic_ok        = inval_found_ff || best_found_ff;
         vic_sel       = inval_found_ff ? inval_idx_ff : best_idx_ff;
         vic_sel_dirty = !inval_found_ff && best_dirty_ff;
         vic_sel_page  = best_page_ff;
      end
   end

   always_comb begin
      stat.is_flush      = (cmd_ff == CMD_FLUSH);
      stat.scan_done     = (scan_addr_ff == n_ff) && !rd_vld_ff;
      stat.need_clock    = (cmd_ff == CMD_PIN) && !match_found_ff && !inval_found_ff
                           && (policy_ff == POL_CLOCK);
      stat.clk_exhausted = (clk_step_ff == STEP_W'({n_ff, 1'b1}));
      stat.clk_hit       = (rd_entry.pins == 8'd0) && !rd_entry.ref_bit;
      stat.fl_done       = (fl_idx_ff == n_ff) || (fl_cnt_ff == RES_CNT_W'(MAX_RESULTS));
      stat.out_free      = out_free;
   end

   always_comb begin
      policy_in      = policy_ff;
      frames_in      = frames_ff;
      cmd_in         = cmd_ff;
      page_in        = page_ff;
      n_in           = n_ff;
      valid_in       = valid_ff;
      rd_en          = 1'b0;
      rd_idx_in      = rd_idx_ff;
      wr_en          = 1'b0;
      wr_addr        = match_idx_ff;
      wr_data        = match_entry_ff;
      rd_vld_in      = scan_issue;
      scan_addr_in   = scan_addr_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_entry_in = match_entry_ff;
      inval_found_in = inval_found_ff;
      inval_idx_in   = inval_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_key_in    = best_key_ff;
      best_dirty_in  = best_dirty_ff;
      best_page_in   = best_page_ff;
      hand_in        = hand_ff;
      clk_h_in       = clk_h_ff;
      clk_step_in    = clk_step_ff;
      vic_found_in   = vic_found_ff;
      vic_idx_in     = vic_idx_ff;
      vic_dirty_in   = vic_dirty_ff;
      vic_page_in    = vic_page_ff;
      fl_idx_in      = fl_idx_ff;
      fl_cnt_in      = fl_cnt_ff;
      pend_vld_in    = pend_vld_ff;
      pend_idx_in    = pend_idx_ff;
      pend_page_in   = pend_page_ff;
      pend_wtot_in   = pend_wtot_ff;
      tick_in        = tick_ff;
      loads_in       = loads_ff;
      writes_in      = writes_ff;
      out_push       = 1'b0;
      o_status       = STS_OK;
      o_idx          = '0;
      o_hit          = 1'b0;
      o_ld           = 1'b0;
      o_wv           = 1'b0;
      o_page         = '0;
      o_rtot         = loads_ff;
      o_wtot         = writes_ff;
      o_last         = 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            REG_POLICY: policy_in = csr_wdata[1:0];
            REG_FRAMES: frames_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      if (ctl.load_req) begin
         cmd_in         = req_cmd;
         page_in        = req_page_number;
         n_in           = n_cfg;
         scan_addr_in   = '0;
         match_found_in = 1'b0;
         inval_found_in = 1'b0;
         best_found_in  = 1'b0;
         vic_found_in   = 1'b0;
         clk_h_in       = (CNT_W'(hand_ff) < n_cfg) ? hand_ff : '0;
         clk_step_in    = '0;
         fl_idx_in      = '0;
         fl_cnt_in      = '0;
         pend_vld_in    = 1'b0;
      end

      // lookup scan: issue one read a cycle, judge the word read last cycle
      if (scan_issue) begin
         rd_en        = 1'b1;
         rd_idx_in    = scan_addr_ff[IDX_W-1:0];
         scan_addr_in = scan_addr_ff + CNT_W'(1);
      end
      if (ctl.scan_step && rd_vld_ff) begin
         if (valid_ff[rd_idx_ff] && (rd_entry.page == page_ff) && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
            match_entry_in = rd_entry;
         end
         if (!valid_ff[rd_idx_ff] && !inval_found_ff) begin
            inval_found_in = 1'b1;
            inval_idx_in   = rd_idx_ff;
         end
         if ((rd_entry.pins == 8'd0) && (!best_found_ff || (key < best_key_ff))) begin
            best_found_in = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_key_in   = key;
            best_dirty_in = rd_entry.dirty;
            best_page_in  = rd_entry.page;
         end
      end

      if (ctl.clk_read) begin
         rd_en     = 1'b1;
         rd_idx_in = clk_h_ff;
      end
      if (ctl.clk_eval) begin
         clk_step_in = clk_step_ff + STEP_W'(1);
         clk_h_in    = clk_h_nx;
         if (stat.clk_hit) begin
            vic_found_in = 1'b1;
            vic_idx_in   = clk_h_ff;
            vic_dirty_in = rd_entry.dirty;
            vic_page_in  = rd_entry.page;
            hand_in      = clk_h_nx;
         end else if (rd_entry.pins == 8'd0) begin
            // second chance: drop the reference bit and move on
            wr_en           = 1'b1;
            wr_addr         = clk_h_ff;
            wr_data         = rd_entry;
            wr_data.ref_bit = 1'b0;
         end
      end

      if (ctl.finish) begin
         out_push = 1'b1;
         unique case (cmd_ff)
            CMD_PIN: begin
               if (match_found_ff) begin
                  wr_en             = 1'b1;
                  wr_addr           = match_idx_ff;
                  wr_data           = match_entry_ff;
                  wr_data.pins      = sat_inc8(match_entry_ff.pins);
                  wr_data.hits      = sat_inc16(match_entry_ff.hits);
                  wr_data.ref_bit   = 1'b1;
                  wr_data.use_stamp = tick_ff;
                  tick_in           = sat_inc32(tick_ff);
                  o_idx             = match_idx_ff;
                  o_hit             = 1'b1;
               end else if (!vic_ok) begin
                  o_status = STS_NO_FRAME;
               end else begin
                  wr_en              = 1'b1;
                  wr_addr            = vic_sel;
                  wr_data.page       = page_ff;
                  wr_data.pins       = 8'd1;
                  wr_data.dirty      = 1'b0;
                  wr_data.hits       = 16'd1;
                  wr_data.use_stamp  = tick_ff;
                  wr_data.load_stamp = tick_ff;
                  wr_data.ref_bit    = 1'b1;
                  valid_in[vic_sel]  = 1'b1;
                  tick_in            = sat_inc32(tick_ff);
                  loads_in           = sat_inc32(loads_ff);
                  if (vic_sel_dirty) begin
                     writes_in = sat_inc32(writes_ff);
                     o_wv      = 1'b1;
                     o_page    = vic_sel_page;
                  end
                  o_idx = vic_sel;
                  o_ld  = 1'b1;
               end
            end
            CMD_UNPIN, CMD_DIRTY, CMD_FORCE: begin
               if (!match_found_ff) begin
                  o_status = STS_NOT_RES;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = match_idx_ff;
                  wr_data = match_entry_ff;
                  o_idx   = match_idx_ff;
                  if (cmd_ff == CMD_UNPIN) begin
                     if (match_entry_ff.pins != 8'd0) wr_data.pins = match_entry_ff.pins - 8'd1;
                  end else if (cmd_ff == CMD_DIRTY) begin
                     wr_data.dirty = 1'b1;
                  end else begin
                     wr_data.dirty = 1'b0;
                     writes_in     = sat_inc32(writes_ff);
                     o_wv          = 1'b1;
                     o_page        = match_entry_ff.page;
                  end
               end
            end
            default: ;
         endcase
         o_rtot = loads_in;
         o_wtot = writes_in;
      end

      if (ctl.fl_read) begin
         rd_en     = 1'b1;
         rd_idx_in = fl_idx_ff[IDX_W-1:0];
      end
      if (ctl.fl_eval) begin
         fl_idx_in = fl_idx_ff + CNT_W'(1);
         if (fl_qual) begin
            wr_en         = 1'b1;
            wr_addr       = rd_idx_ff;
            wr_data       = rd_entry;
            wr_data.dirty = 1'b0;
            writes_in     = sat_inc32(writes_ff);
            fl_cnt_in     = fl_cnt_ff + RES_CNT_W'(1);
            // release the held word now that another one follows it
            if (pend_vld_ff) begin
               out_push = 1'b1;
               o_idx    = pend_idx_ff;
               o_wv     = 1'b1;
               o_page   = pend_page_ff;
               o_wtot   = pend_wtot_ff;
               o_last   = 1'b0;
            end
            pend_vld_in  = 1'b1;
            pend_idx_in  = rd_idx_ff;
            pend_page_in = rd_entry.page;
            pend_wtot_in = writes_in;
         end
      end
      if (ctl.fl_end) begin
         out_push = 1'b1;
         if (pend_vld_ff) begin
            o_idx  = pend_idx_ff;
            o_wv   = 1'b1;
            o_page = pend_page_ff;
            o_wtot = pend_wtot_ff;
         end
      end

      if (out_push) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_raw_ff <= mem[rd_idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= POL_LRU;
         frames_ff      <= 5'd16;
         valid_ff       <= '0;
         rd_vld_ff      <= 1'b0;
         scan_addr_ff   <= '0;
         match_found_ff <= 1'b0;
         inval_found_ff <= 1'b0;
         best_found_ff  <= 1'b0;
         vic_found_ff   <= 1'b0;
         hand_ff        <= '0;
         clk_h_ff       <= '0;
         clk_step_ff    <= '0;
         fl_idx_ff      <= '0;
         fl_cnt_ff      <= '0;
         pend_vld_ff    <= 1'b0;
         tick_ff        <= '0;
         loads_ff       <= '0;
         writes_ff      <= '0;
         cmd_ff         <= '0;
         n_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         policy_ff      <= policy_in;
         frames_ff      <= frames_in;
         valid_ff       <= valid_in;
         rd_vld_ff      <= rd_vld_in;
         scan_addr_ff   <= scan_addr_in;
         match_found_ff <= match_found_in;
         inval_found_ff <= inval_found_in;
         best_found_ff  <= best_found_in;
         vic_found_ff   <= vic_found_in;
         hand_ff        <= hand_in;
         clk_h_ff       <= clk_h_in;
         clk_step_ff    <= clk_step_in;
         fl_idx_ff      <= fl_idx_in;
         fl_cnt_ff      <= fl_cnt_in;
         pend_vld_ff    <= pend_vld_in;
         tick_ff        <= tick_in;
         loads_ff       <= loads_in;
         writes_ff      <= writes_in;
         cmd_ff         <= cmd_in;
         n_ff           <= n_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      rd_idx_ff      <= rd_idx_in;
      match_idx_ff   <= match_idx_in;
      match_entry_ff <= match_entry_in;
      inval_idx_ff   <= inval_idx_in;
      best_idx_ff    <= best_idx_in;
      best_key_ff    <= best_key_in;
      best_dirty_ff  <= best_dirty_in;
      best_page_ff   <= best_page_in;
      vic_idx_ff     <= vic_idx_in;
      vic_dirty_ff   <= vic_dirty_in;
      vic_page_ff    <= vic_page_in;
      pend_idx_ff    <= pend_idx_in;
      pend_page_ff   <= pend_page_in;
      pend_wtot_ff   <= pend_wtot_in;
      if (out_push) begin
         rsp_status_ff <= o_status;
         rsp_fi_ff     <= FIDX_OUT_W'(o_idx);
         rsp_hit_ff    <= o_hit;
         rsp_ld_ff     <= o_ld;
         rsp_wv_ff     <= o_wv;
         rsp_page_ff   <= o_page;
         rsp_rtot_ff   <= o_rtot;
         rsp_wtot_ff   <= o_wtot;
         rsp_last_ff   <= o_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_frame_index     = rsp_fi_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_load_needed     = rsp_ld_ff;
   assign rsp_writeback_valid = rsp_wv_ff;
   assign rsp_writeback_page  = rsp_page_ff;
   assign rsp_read_io_total   = rsp_rtot_ff;
   assign rsp_write_io_total  = rsp_wtot_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// File: src/buffer_pool_frame_manager_top.sv
// Channel   Handshake             Payload
// req       req_valid/req_ready   req_cmd, req_page_number
// rsp       rsp_valid/rsp_ready   status, frame index, flags, writeback page, io totals, last
// csr       csr_valid/csr_ready   csr_index, csr_wdata (0 policy, 1 frames in use)
//
// One command at a time. The lookup scan reads the frame table once per cycle
// through its registered read port; the finish step then updates the table and
// posts the word, and the sequencer returns to idle to take the next command.
// A CLOCK eviction takes a read and an evaluate state per hand step, up to
// 2n + 1 steps. Flush reads and evaluates each frame in turn, then posts the
// last word; a stalled rsp holds the sequencer.
// Reset is synchronous; the table needs no clearing pass.
// Top level of the buffer pool frame manager; depends on bpfm_pkg, bpfm_ctrl, bpfm_datapath.
module buffer_pool_frame_manager_top import bpfm_pkg::*; #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [FIDX_OUT_W-1:0] rsp_frame_index,
   output logic                  rsp_hit,
   output logic                  rsp_load_needed,
   output logic                  rsp_writeback_valid,
   output logic [PAGE_BITS-1:0]  rsp_writeback_page,
   output logic [31:0]           rsp_read_io_total,
   output logic [31:0]           rsp_write_io_total,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   bpfm_cmd_type  ctl;
   bpfm_stat_type stat;

   assign csr_ready = 1'b1;

   bpfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   bpfm_datapath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .req_cmd             (req_cmd),
      .req_page_number     (req_page_number),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_frame_index     (rsp_frame_index),
      .rsp_hit             (rsp_hit),
      .rsp_load_needed     (rsp_load_needed),
      .rsp_writeback_valid (rsp_writeback_valid),
      .rsp_writeback_page  (rsp_writeback_page),
      .rsp_read_io_total   (rsp_read_io_total),
      .rsp_write_io_total  (rsp_write_io_total),
      .rsp_last            (rsp_last)
   );

   // busy after an accepted command
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second command back to back");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |->
         !rsp_hit && !rsp_load_needed && !rsp_writeback_valid && rsp_last)
      else $error("error word carries flags");

   a_hit_or_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_load_needed))
      else $error("hit and load in one word");

   a_flush_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("idle while a flush is still in progress");

endmodule
